FILE: sv/marq_pkg.sv
// ----------------------------------------------------------------------------
// marq_pkg
// Shared types and constants for the multi-resource admission queue.
// ----------------------------------------------------------------------------
`default_nettype none

package marq_pkg;

  localparam int MAX_TYPES      = 8;
  localparam int DEF_NUM_TYPES  = 8;
  localparam int DEF_QUEUE_DEPTH = 16;
  localparam int DEF_RUN_SLOTS  = 16;
  localparam int MAX_RESULTS    = 16;
  localparam int ID_W           = 16;
  localparam int DEM_W          = 5;
  localparam int LIM_W          = 8;
  localparam int CFG_IDX_W      = 3;
  localparam int EV_W           = 3;
  localparam int NRES_W         = $clog2(MAX_RESULTS + 1);

  localparam logic CMD_SUBMIT  = 1'b0;
  localparam logic CMD_RELEASE = 1'b1;

  localparam logic [EV_W-1:0] EV_ADMITTED   = 3'd0;
  localparam logic [EV_W-1:0] EV_QUEUED     = 3'd1;
  localparam logic [EV_W-1:0] EV_DISPATCHED = 3'd2;
  localparam logic [EV_W-1:0] EV_RELEASED   = 3'd3;
  localparam logic [EV_W-1:0] EV_REJECTED   = 3'd4;
  localparam logic [EV_W-1:0] EV_UNKNOWN    = 3'd5;

  // per-lane update command
  typedef struct packed {
    logic add;
    logic sub;
  } lane_ctl_t;

endpackage

`default_nettype wire

FILE: sv/marq_type_lane.sv
// ----------------------------------------------------------------------------
// marq_type_lane
// One resource type: limit register, in-use counter and fit check.
// ----------------------------------------------------------------------------
`default_nettype none

module marq_type_lane
  import marq_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             lim_we,
  input  wire logic [LIM_W-1:0] lim_data,
  input  wire lane_ctl_t        ctl,
  input  wire logic [DEM_W-1:0] dem,
  output logic                  fit
);

  logic [LIM_W-1:0] limit;
  logic [LIM_W-1:0] in_use;
  logic [LIM_W:0]   sum;

  assign sum = {1'b0, in_use} + {{(LIM_W+1-DEM_W){1'b0}}, dem};
  assign fit = sum <= {1'b0, limit};

  always_ff @(posedge clk) begin
    if (rst) begin
      limit  <= '0;
      in_use <= '0;
    end else begin
      if (lim_we) begin
        limit <= lim_data;
      end
      if (ctl.add) begin
        in_use <= sum[LIM_W-1:0];
      end else if (ctl.sub) begin
        // saturate at zero
        in_use <= (in_use >= {{(LIM_W-DEM_W){1'b0}}, dem}) ?
                  in_use - {{(LIM_W-DEM_W){1'b0}}, dem} : '0;
      end
    end
  end

endmodule

`default_nettype wire

FILE: sv/multi_resource_admission_queue.sv
// ----------------------------------------------------------------------------
// multi_resource_admission_queue
// Admits jobs against per-type limits; queues the rest and dispatches on
// release.
// ----------------------------------------------------------------------------
// Submit: result from S_SUB. Release: running slots are scanned (RUN_SLOTS
// slots worst case) in S_RD then S_CMP to find the id, then queue heads are
// checked in S_DRD then S_DCHK, as the single-port slot and queue memories have registered reads.
// A new start can be taken at the edge that ends the final result beat.
// Results cannot be stalled; each strobe lasts one cycle.
// Synchronous reset clears counters, valid bits, limits and control state.
`default_nettype none

module multi_resource_admission_queue
  import marq_pkg::*;
#(
  parameter int NUM_TYPES   = DEF_NUM_TYPES,
  parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
  parameter int RUN_SLOTS   = DEF_RUN_SLOTS
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx,
  input  wire logic [LIM_W-1:0]     cfg_data,
  input  wire logic                 start,
  output logic                      busy,
  input  wire logic                 cmd,
  input  wire logic [ID_W-1:0]      job_id,
  input  wire logic [DEM_W-1:0]     demand_0,
  input  wire logic [DEM_W-1:0]     demand_1,
  input  wire logic [DEM_W-1:0]     demand_2,
  input  wire logic [DEM_W-1:0]     demand_3,
  input  wire logic [DEM_W-1:0]     demand_4,
  input  wire logic [DEM_W-1:0]     demand_5,
  input  wire logic [DEM_W-1:0]     demand_6,
  input  wire logic [DEM_W-1:0]     demand_7,
  output logic                      valid,
  output logic [EV_W-1:0]           event_res,
  output logic [ID_W-1:0]           out_job_id,
  output logic                      last
);

  localparam int REC_W = ID_W + DEM_W * NUM_TYPES;
  localparam int QA_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QC_W  = $clog2(QUEUE_DEPTH + 1);
  localparam int SA_W  = (RUN_SLOTS > 1) ? $clog2(RUN_SLOTS) : 1;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SUB  = 3'd1;
  localparam logic [2:0] S_RD   = 3'd2;
  localparam logic [2:0] S_CMP  = 3'd3;
  localparam logic [2:0] S_DRD  = 3'd4;
  localparam logic [2:0] S_DCHK = 3'd5;

  logic [2:0]       state;
  logic             cmd_q;
  logic [REC_W-1:0] in_rec;
  logic [REC_W-1:0] run_mem [RUN_SLOTS];
  logic [REC_W-1:0] q_mem [QUEUE_DEPTH];
  logic [REC_W-1:0] run_rd;
  logic [REC_W-1:0] q_rd;
  logic [RUN_SLOTS-1:0] slot_valid;
  logic [QC_W-1:0]  count;
  logic [QA_W-1:0]  head;
  logic [QA_W:0]    tail_sum;
  logic [QA_W-1:0]  tail;
  logic [SA_W-1:0]  scan_idx;
  logic [NRES_W-1:0] nres;
  logic [ID_W-1:0]  held_id;
  logic [SA_W-1:0]  free_idx;
  logic             free_any;
  logic [DEM_W-1:0] dem_in [MAX_TYPES];
  logic [REC_W-1:0] lane_rec;
  logic [NUM_TYPES-1:0] fit;
  logic             fit_all;
  lane_ctl_t        ctl;

  assign dem_in[0] = demand_0;
  assign dem_in[1] = demand_1;
  assign dem_in[2] = demand_2;
  assign dem_in[3] = demand_3;
  assign dem_in[4] = demand_4;
  assign dem_in[5] = demand_5;
  assign dem_in[6] = demand_6;
  assign dem_in[7] = demand_7;

  assign busy = state != S_IDLE;

  // lowest free slot
  always_comb begin
    free_idx = '0;
    for (int s = RUN_SLOTS - 1; s >= 0; s--) begin
      if (!slot_valid[s]) begin
        free_idx = SA_W'(s);
      end
    end
  end
  assign free_any = ~&slot_valid;

  assign tail_sum = {1'b0, head} + (QA_W+1)'(count);
  assign tail = (tail_sum >= (QA_W+1)'(QUEUE_DEPTH)) ?
                QA_W'(tail_sum - (QA_W+1)'(QUEUE_DEPTH)) : QA_W'(tail_sum);

  // record the lanes look at depends on the phase
  always_comb begin
    case (state)
      S_CMP:   lane_rec = run_rd;
      S_DCHK:  lane_rec = q_rd;
      default: lane_rec = in_rec;
    endcase
  end

  always_comb begin
    ctl = '0;
    case (state)
      S_SUB:   ctl.add = (count == '0) && free_any && fit_all;
      S_CMP:   ctl.sub = slot_valid[scan_idx] && (run_rd[ID_W-1:0] == in_rec[ID_W-1:0]);
      S_DCHK:  ctl.add = free_any && fit_all;
      default: ctl = '0;
    endcase
  end

  assign fit_all = &fit;

  for (genvar k = 0; k < NUM_TYPES; k++) begin : g_lane
    marq_type_lane u_lane (
      .clk      (clk),
      .rst      (rst),
      .lim_we   (cfg_we && (cfg_idx == CFG_IDX_W'(k))),
      .lim_data (cfg_data),
      .ctl      (ctl),
      .dem      (lane_rec[ID_W + DEM_W*k +: DEM_W]),
      .fit      (fit[k])
    );
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && start) begin
      in_rec[ID_W-1:0] <= job_id;
      for (int k = 0; k < NUM_TYPES; k++) begin
        in_rec[ID_W + DEM_W*k +: DEM_W] <= dem_in[k];
      end
    end
  end

  // slot memory
  always_ff @(posedge clk) begin
    if ((state == S_SUB || state == S_DCHK) && ctl.add) begin
      run_mem[free_idx] <= lane_rec;
    end
    run_rd <= run_mem[scan_idx];
  end

  // queue memory
  always_ff @(posedge clk) begin
    if (state == S_SUB && !ctl.add && count < QC_W'(QUEUE_DEPTH)) begin
      q_mem[tail] <= in_rec;
    end
    q_rd <= q_mem[head];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      slot_valid <= '0;
      count      <= '0;
      head       <= '0;
      scan_idx   <= '0;
      nres       <= '0;
      valid      <= 1'b0;
      cmd_q      <= CMD_SUBMIT;
    end else begin
      valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            cmd_q    <= cmd;
            scan_idx <= '0;
            nres     <= '0;
            state    <= (cmd == CMD_SUBMIT) ? S_SUB : S_RD;
          end
        end
        S_SUB: begin
          valid      <= 1'b1;
          last       <= 1'b1;
          out_job_id <= in_rec[ID_W-1:0];
          if (ctl.add) begin
            slot_valid[free_idx] <= 1'b1;
            event_res <= EV_ADMITTED;
          end else if (count >= QC_W'(QUEUE_DEPTH)) begin
            event_res <= EV_REJECTED;
          end else begin
            count     <= count + 1'b1;
            event_res <= EV_QUEUED;
          end
          state <= S_IDLE;
        end
        S_RD: begin
          state <= S_CMP;
        end
        S_CMP: begin
          if (ctl.sub) begin
            slot_valid[scan_idx] <= 1'b0;
            state <= S_DRD;
          end else if (scan_idx == SA_W'(RUN_SLOTS - 1)) begin
            valid      <= 1'b1;
            last       <= 1'b1;
            event_res  <= EV_UNKNOWN;
            out_job_id <= in_rec[ID_W-1:0];
            state      <= S_IDLE;
          end else begin
            scan_idx <= scan_idx + 1'b1;
            state    <= S_RD;
          end
        end
        S_DRD: begin
          if (count != '0 && nres < NRES_W'(MAX_RESULTS)) begin
            state <= S_DCHK;
          end else begin
            valid      <= 1'b1;
            last       <= 1'b1;
            event_res  <= (nres == '0) ? EV_RELEASED : EV_DISPATCHED;
            out_job_id <= (nres == '0) ? in_rec[ID_W-1:0] : held_id;
            state      <= S_IDLE;
          end
        end
        S_DCHK: begin
          if (ctl.add) begin
            // emit the previous dispatch now that another one follows
            if (nres != '0) begin
              valid      <= 1'b1;
              last       <= 1'b0;
              event_res  <= EV_DISPATCHED;
              out_job_id <= held_id;
            end
            held_id <= q_rd[ID_W-1:0];
            slot_valid[free_idx] <= 1'b1;
            head  <= (head == QA_W'(QUEUE_DEPTH - 1)) ? '0 : head + 1'b1;
            count <= count - 1'b1;
            nres  <= nres + 1'b1;
            state <= S_DRD;
          end else begin
            valid      <= 1'b1;
            last       <= 1'b1;
            event_res  <= (nres == '0) ? EV_RELEASED : EV_DISPATCHED;
            out_job_id <= (nres == '0) ? in_rec[ID_W-1:0] : held_id;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
      if (cmd_q == CMD_SUBMIT && state == S_CMP) begin
        state <= S_IDLE;
      end
    end
  end

endmodule

`default_nettype wire

FILE: sv/marq_checker.sv
// ----------------------------------------------------------------------------
// marq_checker
// Port-level checks of the admission queue command and result beats.
// ----------------------------------------------------------------------------
`default_nettype none

module marq_checker
  import marq_pkg::*;
(
  input wire logic            clk,
  input wire logic            rst,
  input wire logic            start,
  input wire logic            busy,
  input wire logic            valid,
  input wire logic [EV_W-1:0] event_res,
  input wire logic            last
);

  // an accepted command keeps the block busy next cycle
  a_busy_after_start: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy) else $error("busy not raised after start");

  // more beats follow a non-final one
  a_busy_mid: assert property (@(posedge clk) disable iff (rst)
    valid && !last |-> busy) else $error("idle during multi-beat result");

  // only dispatch beats may be non-final
  a_last: assert property (@(posedge clk) disable iff (rst)
    valid && (event_res != EV_DISPATCHED) |-> last) else $error("missing last");

  // the final beat shows with the block idle again
  a_final_idle: assert property (@(posedge clk) disable iff (rst)
    valid && last |-> !busy) else $error("busy during final result beat");

endmodule

bind multi_resource_admission_queue marq_checker u_marq_checker (
  .clk       (clk),
  .rst       (rst),
  .start     (start),
  .busy      (busy),
  .valid     (valid),
  .event_res (event_res),
  .last      (last)
);

`default_nettype wire
